@@ design/atbp_pkg.sv @@
// shared types and constants for the arm/thumb branch predecoder
// no dependencies; used by atbp_decode, arm_thumb_branch_predecode_top and the testbench

package atbp_pkg;

   // branch class codes
   localparam logic [2:0] KIND_NONE     = 3'd0;
   localparam logic [2:0] KIND_DIRECT   = 3'd1;
   localparam logic [2:0] KIND_COND     = 3'd2;
   localparam logic [2:0] KIND_INDIRECT = 3'd3;
   localparam logic [2:0] KIND_RETURN   = 3'd4;
   localparam logic [2:0] KIND_TABLE    = 3'd5;

   // instruction sizes in bytes
   localparam logic [2:0] SIZE_HALF = 3'd2;
   localparam logic [2:0] SIZE_WORD = 3'd4;

   // thumb16 match patterns
   localparam logic [4:0]  T16_LIMIT_TOP5 = 5'b11101;   // 0xE800 >> 11
   localparam logic [15:0] T16_COND_MASK  = 16'hF000;
   localparam logic [15:0] T16_COND_PAT   = 16'hD000;
   localparam logic [15:0] T16_B_MASK     = 16'hF800;
   localparam logic [15:0] T16_B_PAT      = 16'hE000;
   localparam logic [15:0] T16_BX_MASK    = 16'hFF80;
   localparam logic [15:0] T16_BX_PAT     = 16'h4780;
   localparam logic [15:0] T16_POP_MASK   = 16'hFF00;
   localparam logic [15:0] T16_POP_PAT    = 16'hBD00;
   localparam logic [3:0]  REG_LR         = 4'hE;

   // thumb32 match patterns
   localparam logic [31:0] T32_BR_MASK  = 32'hF800D000;
   localparam logic [31:0] T32_B_PAT    = 32'hF0008000;
   localparam logic [31:0] T32_BC_PAT   = 32'hF0009000;
   localparam logic [31:0] T32_BL_PAT   = 32'hF000D000;
   localparam logic [31:0] T32_TBB_MASK = 32'hFFF0D000;
   localparam logic [31:0] T32_TBB_PAT  = 32'hE890D000;

   // arm match patterns
   localparam logic [31:0] ARM_B_MASK   = 32'h0E000000;
   localparam logic [31:0] ARM_B_PAT    = 32'h0A000000;
   localparam logic [31:0] ARM_BX_MASK  = 32'h0FFFFFF0;
   localparam logic [31:0] ARM_BX_PAT   = 32'h012FFF10;
   localparam logic [31:0] ARM_BLX_PAT  = 32'h012FFF30;
   localparam logic [31:0] ARM_LDM_MASK = 32'h0E108000;
   localparam logic [31:0] ARM_LDM_PAT  = 32'h08108000;

   // pc bias seen by branches
   localparam logic [31:0] THUMB_PC_BIAS = 32'd4;
   localparam logic [31:0] ARM_PC_BIAS   = 32'd8;

   // decode result handed to the target stage
   typedef struct packed {
      logic [2:0]  size;
      logic [2:0]  kind;
      logic        has_target;
      logic [31:0] offset;
      logic [31:0] base;
   } decode_type;

endpackage

@@ design/atbp_decode.sv @@
// instruction classifier: size, branch class, sign-extended offset and pc base
// depends on atbp_pkg

module atbp_decode (
   input  logic [31:0]        pc_address,
   input  logic               thumb_mode,
   input  logic [15:0]        half_first,
   input  logic [15:0]        half_second,
   output atbp_pkg::decode_type dec
);

   logic        is_t16;
   logic [31:0] t32_op;
   logic [31:0] arm_op;
   logic [31:0] t32_masked;
   logic [31:0] t16_cond_off;
   logic [31:0] t16_b_off;
   logic [31:0] t32_off;
   logic [31:0] arm_off;
   logic        t32_s;
   logic        t32_i1;
   logic        t32_i2;

   assign is_t16     = thumb_mode && (half_first[15:11] < atbp_pkg::T16_LIMIT_TOP5);
   assign t32_op     = {half_first, half_second};
   assign arm_op     = {half_second, half_first};
   assign t32_masked = t32_op & atbp_pkg::T32_BR_MASK;

   // branch offsets, sign extended
   assign t16_cond_off = {{23{half_first[7]}}, half_first[7:0], 1'b0};
   assign t16_b_off    = {{20{half_first[10]}}, half_first[10:0], 1'b0};
   assign t32_s        = t32_op[26];
   assign t32_i1       = ~(t32_op[13] ^ t32_s);
   assign t32_i2       = ~(t32_op[11] ^ t32_s);
   assign t32_off      = {{7{t32_s}}, t32_s, t32_i1, t32_i2, t32_op[25:16],
                          t32_op[10:0], 1'b0};
   assign arm_off      = {{6{arm_op[23]}}, arm_op[23:0], 2'b00};

   // classification, first match wins
   always_comb begin
      // pc base for target arithmetic
      dec.base       = pc_address + (thumb_mode ? atbp_pkg::THUMB_PC_BIAS
                                                : atbp_pkg::ARM_PC_BIAS);
      dec.size       = atbp_pkg::SIZE_WORD;
      dec.kind       = atbp_pkg::KIND_NONE;
      dec.has_target = 1'b0;
      dec.offset     = '0;
      if (is_t16) begin
         dec.size = atbp_pkg::SIZE_HALF;
         priority if ((half_first & atbp_pkg::T16_COND_MASK) == atbp_pkg::T16_COND_PAT) begin
            dec.kind       = atbp_pkg::KIND_COND;
            dec.has_target = 1'b1;
            dec.offset     = t16_cond_off;
         end else if ((half_first & atbp_pkg::T16_B_MASK) == atbp_pkg::T16_B_PAT) begin
            dec.kind       = atbp_pkg::KIND_DIRECT;
            dec.has_target = 1'b1;
            dec.offset     = t16_b_off;
         end else if ((half_first & atbp_pkg::T16_BX_MASK) == atbp_pkg::T16_BX_PAT) begin
            dec.kind = (half_first[6:3] == atbp_pkg::REG_LR) ? atbp_pkg::KIND_RETURN
                                                             : atbp_pkg::KIND_INDIRECT;
         end else if ((half_first & atbp_pkg::T16_POP_MASK) == atbp_pkg::T16_POP_PAT) begin
            dec.kind = atbp_pkg::KIND_RETURN;
         end else begin
            dec.kind = atbp_pkg::KIND_NONE;
         end
      end else if (thumb_mode) begin
         priority if (t32_masked == atbp_pkg::T32_B_PAT
                      || t32_masked == atbp_pkg::T32_BL_PAT) begin
            dec.kind       = atbp_pkg::KIND_DIRECT;
            dec.has_target = 1'b1;
            dec.offset     = t32_off;
         end else if (t32_masked == atbp_pkg::T32_BC_PAT) begin
            dec.kind       = atbp_pkg::KIND_COND;
            dec.has_target = 1'b1;
            dec.offset     = t32_off;
         end else if ((t32_op & atbp_pkg::T32_TBB_MASK) == atbp_pkg::T32_TBB_PAT) begin
            dec.kind = atbp_pkg::KIND_TABLE;
         end else begin
            dec.kind = atbp_pkg::KIND_NONE;
         end
      end else begin
         priority if ((arm_op & atbp_pkg::ARM_B_MASK) == atbp_pkg::ARM_B_PAT) begin
            dec.kind       = atbp_pkg::KIND_DIRECT;
            dec.has_target = 1'b1;
            dec.offset     = arm_off;
         end else if ((arm_op & atbp_pkg::ARM_BX_MASK) == atbp_pkg::ARM_BX_PAT) begin
            dec.kind = (arm_op[3:0] == atbp_pkg::REG_LR) ? atbp_pkg::KIND_RETURN
                                                         : atbp_pkg::KIND_INDIRECT;
         end else if ((arm_op & atbp_pkg::ARM_BX_MASK) == atbp_pkg::ARM_BLX_PAT) begin
            dec.kind = atbp_pkg::KIND_INDIRECT;
         end else if ((arm_op & atbp_pkg::ARM_LDM_MASK) == atbp_pkg::ARM_LDM_PAT) begin
            dec.kind = atbp_pkg::KIND_RETURN;
         end else begin
            dec.kind = atbp_pkg::KIND_NONE;
         end
      end
   end

endmodule

@@ design/arm_thumb_branch_predecode_top.sv @@
// arm/thumb branch predecoder top level: three-stage pipeline around atbp_decode
// depends on atbp_pkg and atbp_decode
//
// usage
//   req_ channel carries one fetched instruction per transfer: its address,
//   the thumb state bit and the two halfwords at address and address+2.
//   rsp_ channel returns one result per request, in order: size in bytes,
//   branch class, branch target (direct and conditional only, else zero)
//   and the end-of-basic-block flag.
//   a request passes the input register, the decode register and the output
//   register in that order before its result is shown on rsp_.
//   throughput: one transfer per cycle on both sides while rsp_ready is high, set by
//   the single pass through the decode stage and one 32-bit add in the target stage.
//   reset clears the stage valid bits; the pipeline is empty and req_ready is
//   high in the first cycle after reset.
//   when the receiver stalls, each stage holds until the stage after it frees
//   up; bubbles are squeezed out, so the pipeline fills to three items and up
//   to two requests are taken in behind a waiting result, then req_ready drops.

module arm_thumb_branch_predecode_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_pc_address,
   input  logic        req_thumb_mode,
   input  logic [15:0] req_half_first,
   input  logic [15:0] req_half_second,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_insn_size,
   output logic [2:0]  rsp_branch_kind,
   output logic [31:0] rsp_branch_target,
   output logic        rsp_ends_block
);

   // stage valid bits
   logic s1_valid_ff;
   logic s2_valid_ff;
   logic s3_valid_ff;
   logic s1_ready;
   logic s2_ready;
   logic s3_ready;

   // stage payload
   logic [31:0]          s1_pc_ff;
   logic                 s1_thumb_ff;
   logic [15:0]          s1_h1_ff;
   logic [15:0]          s1_h2_ff;
   atbp_pkg::decode_type s2_dec_in;
   atbp_pkg::decode_type s2_dec_ff;
   logic [31:0]          s3_target_in;
   logic [2:0]           s3_size_ff;
   logic [2:0]           s3_kind_ff;
   logic [31:0]          s3_target_ff;

   // per-stage ready: a stage takes new data when empty or draining
   assign s3_ready  = !s3_valid_ff || rsp_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;

   // stage 1: input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_valid;
      end
      if (s1_ready && req_valid) begin
         s1_pc_ff    <= req_pc_address;
         s1_thumb_ff <= req_thumb_mode;
         s1_h1_ff    <= req_half_first;
         s1_h2_ff    <= req_half_second;
      end
   end

   // stage 2: classification and offset extraction
   atbp_decode u_decode (
      .pc_address  (s1_pc_ff),
      .thumb_mode  (s1_thumb_ff),
      .half_first  (s1_h1_ff),
      .half_second (s1_h2_ff),
      .dec         (s2_dec_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_dec_ff <= s2_dec_in;
      end
   end

   // stage 3: target add, zero for non-relative branches
   assign s3_target_in = s2_dec_ff.has_target ? (s2_dec_ff.base + s2_dec_ff.offset) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_size_ff   <= s2_dec_ff.size;
         s3_kind_ff   <= s2_dec_ff.kind;
         s3_target_ff <= s3_target_in;
      end
   end

   // result channel
   assign rsp_valid         = s3_valid_ff;
   assign rsp_insn_size     = s3_size_ff;
   assign rsp_branch_kind   = s3_kind_ff;
   assign rsp_branch_target = s3_target_ff;
   assign rsp_ends_block    = (s3_kind_ff != atbp_pkg::KIND_NONE);

   // checks
   a_empty_pipe_ready: assert property (@(posedge clock) disable iff (reset)
      (!s1_valid_ff && !s2_valid_ff && !s3_valid_ff) |-> req_ready)
      else $error("empty pipeline not ready for a request");

   a_target_only_relative: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_branch_kind != atbp_pkg::KIND_DIRECT
                 && rsp_branch_kind != atbp_pkg::KIND_COND) |-> (rsp_branch_target == '0))
      else $error("nonzero target on a non-relative result");

   a_size_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_insn_size == atbp_pkg::SIZE_HALF
                     || rsp_insn_size == atbp_pkg::SIZE_WORD))
      else $error("illegal instruction size");

   a_no_drop_on_stall: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && rsp_valid && !rsp_ready) |=> s2_valid_ff)
      else $error("decoded item lost during output stall");

endmodule

@@ test/arm_thumb_branch_predecode_top_test.sv @@
// self-checking testbench for arm_thumb_branch_predecode_top: directed and random fetches
// depends on atbp_pkg and the design files; predicts each result with its own branch decoder

module arm_thumb_branch_predecode_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_FETCHES = 1650;
   localparam int CALM_TAIL      = 150;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int DRAIN_CYCLES   = 8;

   typedef struct packed {
      logic [31:0] pc;
      logic        thumb;
      logic [15:0] h1;
      logic [15:0] h2;
   } fetch_item_type;

   typedef struct packed {
      logic [2:0]  size;
      logic [2:0]  kind;
      logic [31:0] target;
      logic        ends_block;
   } branch_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_pc_address = '0;
   logic        req_thumb_mode = 1'b0;
   logic [15:0] req_half_first = '0;
   logic [15:0] req_half_second = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_insn_size;
   logic [2:0]  rsp_branch_kind;
   logic [31:0] rsp_branch_target;
   logic        rsp_ends_block;

   fetch_item_type    fetch_queue[$];
   branch_result_type predicted_branches[$];
   fetch_item_type    fetch_on_bus;
   int                mismatch_count = 0;
   int                cycle_count = 0;
   int                send_gap = 0;
   int                recv_gap = 0;
   int                send_idle_pct = 0;
   int                recv_idle_pct = 0;

   arm_thumb_branch_predecode_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_pc_address    (req_pc_address),
      .req_thumb_mode    (req_thumb_mode),
      .req_half_first    (req_half_first),
      .req_half_second   (req_half_second),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_insn_size     (rsp_insn_size),
      .rsp_branch_kind   (rsp_branch_kind),
      .rsp_branch_target (rsp_branch_target),
      .rsp_ends_block    (rsp_ends_block)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // branch decoder: size, class and target of one fetched instruction
   function automatic branch_result_type decode_branch(fetch_item_type f);
      branch_result_type r;
      logic [31:0]       op;
      logic [31:0]       hit;
      logic [31:0]       t32_off;
      logic              s;
      r.size       = atbp_pkg::SIZE_WORD;
      r.kind       = atbp_pkg::KIND_NONE;
      r.target     = '0;
      r.ends_block = 1'b0;
      if (f.thumb && f.h1[15:11] < atbp_pkg::T16_LIMIT_TOP5) begin
         r.size = atbp_pkg::SIZE_HALF;
         if ((f.h1 & atbp_pkg::T16_COND_MASK) == atbp_pkg::T16_COND_PAT) begin
            r.kind   = atbp_pkg::KIND_COND;
            r.target = f.pc + atbp_pkg::THUMB_PC_BIAS + {{23{f.h1[7]}}, f.h1[7:0], 1'b0};
         end else if ((f.h1 & atbp_pkg::T16_B_MASK) == atbp_pkg::T16_B_PAT) begin
            r.kind   = atbp_pkg::KIND_DIRECT;
            r.target = f.pc + atbp_pkg::THUMB_PC_BIAS + {{20{f.h1[10]}}, f.h1[10:0], 1'b0};
         end else if ((f.h1 & atbp_pkg::T16_BX_MASK) == atbp_pkg::T16_BX_PAT) begin
            r.kind = (f.h1[6:3] == atbp_pkg::REG_LR) ? atbp_pkg::KIND_RETURN
                                                     : atbp_pkg::KIND_INDIRECT;
         end else if ((f.h1 & atbp_pkg::T16_POP_MASK) == atbp_pkg::T16_POP_PAT) begin
            r.kind = atbp_pkg::KIND_RETURN;
         end
      end else if (f.thumb) begin
         op  = {f.h1, f.h2};
         hit = op & atbp_pkg::T32_BR_MASK;
         s   = op[26];
         t32_off = {{7{s}}, s, ~(op[13] ^ s), ~(op[11] ^ s), op[25:16], op[10:0], 1'b0};
         if (hit == atbp_pkg::T32_B_PAT || hit == atbp_pkg::T32_BL_PAT) begin
            r.kind   = atbp_pkg::KIND_DIRECT;
            r.target = f.pc + atbp_pkg::THUMB_PC_BIAS + t32_off;
         end else if (hit == atbp_pkg::T32_BC_PAT) begin
            r.kind   = atbp_pkg::KIND_COND;
            r.target = f.pc + atbp_pkg::THUMB_PC_BIAS + t32_off;
         end else if ((op & atbp_pkg::T32_TBB_MASK) == atbp_pkg::T32_TBB_PAT) begin
            r.kind = atbp_pkg::KIND_TABLE;
         end
      end else begin
         op = {f.h2, f.h1};
         if ((op & atbp_pkg::ARM_B_MASK) == atbp_pkg::ARM_B_PAT) begin
            r.kind   = atbp_pkg::KIND_DIRECT;
            r.target = f.pc + atbp_pkg::ARM_PC_BIAS + {{6{op[23]}}, op[23:0], 2'b00};
         end else if ((op & atbp_pkg::ARM_BX_MASK) == atbp_pkg::ARM_BX_PAT) begin
            r.kind = (op[3:0] == atbp_pkg::REG_LR) ? atbp_pkg::KIND_RETURN
                                                   : atbp_pkg::KIND_INDIRECT;
         end else if ((op & atbp_pkg::ARM_BX_MASK) == atbp_pkg::ARM_BLX_PAT) begin
            r.kind = atbp_pkg::KIND_INDIRECT;
         end else if ((op & atbp_pkg::ARM_LDM_MASK) == atbp_pkg::ARM_LDM_PAT) begin
            r.kind = atbp_pkg::KIND_RETURN;
         end
      end
      r.ends_block = (r.kind != atbp_pkg::KIND_NONE);
      return r;
   endfunction

   // force the bits under mask to a match pattern, keep the rest
   function automatic logic [31:0] imprint(logic [31:0] value, logic [31:0] mask,
                                           logic [31:0] pat);
      return (value & ~mask) | (pat & mask);
   endfunction

   // random fetch, mostly shaped into one of the branch encodings
   function automatic fetch_item_type random_fetch();
      fetch_item_type f;
      logic [31:0]    op;
      int             shaped;
      f.pc  = $urandom;
      if ($urandom_range(0, 19) == 0) begin
         f.pc = $urandom_range(0, 1) ? $urandom_range(0, 15)
                                     : 32'hFFFFFFFF - $urandom_range(0, 15);
      end
      op     = $urandom;
      shaped = ($urandom_range(0, 9) < 7);
      case ($urandom_range(0, 2))
         0: begin
            f.thumb = 1'b1;
            if (shaped) begin
               case ($urandom_range(0, 4))
                  0: op = imprint(op, 32'hF0000000, 32'hD0000000);
                  1: op = imprint(op, 32'hF8000000, 32'hE0000000);
                  2: op = imprint(op, 32'hFF800000, 32'h47800000);
                  3: op = imprint(op, 32'hFFF80000, 32'h47F00000);
                  default: op = imprint(op, 32'hFF000000, 32'hBD000000);
               endcase
            end else if ($urandom_range(0, 1)) begin
               op[31:27] = 5'($urandom_range(0, 28));
            end
         end
         1: begin
            f.thumb = 1'b1;
            if (shaped) begin
               case ($urandom_range(0, 3))
                  0: op = imprint(op, atbp_pkg::T32_BR_MASK, atbp_pkg::T32_B_PAT);
                  1: op = imprint(op, atbp_pkg::T32_BR_MASK, atbp_pkg::T32_BC_PAT);
                  2: op = imprint(op, atbp_pkg::T32_BR_MASK, atbp_pkg::T32_BL_PAT);
                  default: op = imprint(op, atbp_pkg::T32_TBB_MASK, atbp_pkg::T32_TBB_PAT);
               endcase
            end else begin
               op[31:27] = 5'($urandom_range(29, 31));
            end
         end
         default: begin
            f.thumb = 1'b0;
            if (shaped) begin
               case ($urandom_range(0, 4))
                  0: op = imprint(op, atbp_pkg::ARM_B_MASK, atbp_pkg::ARM_B_PAT);
                  1: op = imprint(op, atbp_pkg::ARM_BX_MASK, atbp_pkg::ARM_BX_PAT);
                  2: op = imprint(op, 32'h0FFFFFFF, 32'h012FFF1E);
                  3: op = imprint(op, atbp_pkg::ARM_BX_MASK, atbp_pkg::ARM_BLX_PAT);
                  default: op = imprint(op, atbp_pkg::ARM_LDM_MASK, atbp_pkg::ARM_LDM_PAT);
               endcase
            end
         end
      endcase
      // thumb puts the first halfword on top, arm the low half of the word
      if (f.thumb) begin
         f.h1 = op[31:16];
         f.h2 = op[15:0];
      end else begin
         f.h1 = op[15:0];
         f.h2 = op[31:16];
      end
      return f;
   endfunction

   task automatic queue_fetch(input logic [31:0] pc, input logic thumb,
                              input logic [15:0] h1, input logic [15:0] h2);
      fetch_item_type f;
      f.pc    = pc;
      f.thumb = thumb;
      f.h1    = h1;
      f.h2    = h2;
      fetch_queue = {fetch_queue, f};
   endtask

   // cycle counter, idle mix changes and run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 50 == 0) begin
         case ($urandom_range(0, 3))
            0: send_idle_pct = 0;
            1: send_idle_pct = 5;
            2: send_idle_pct = 15;
            default: send_idle_pct = 35;
         endcase
         case ($urandom_range(0, 3))
            0: recv_idle_pct = 0;
            1: recv_idle_pct = 5;
            2: recv_idle_pct = 15;
            default: recv_idle_pct = 35;
         endcase
      end
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // request driver: record each transfer, then present the next fetch or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predicted_branches = {predicted_branches, decode_branch(fetch_on_bus)};
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap = send_gap - 1;
               req_valid <= 1'b0;
            end else if (fetch_queue.size() > 0) begin
               fetch_on_bus = fetch_queue.pop_front();
               req_pc_address  <= fetch_on_bus.pc;
               req_thumb_mode  <= fetch_on_bus.thumb;
               req_half_first  <= fetch_on_bus.h1;
               req_half_second <= fetch_on_bus.h2;
               req_valid       <= 1'b1;
               if (fetch_queue.size() > CALM_TAIL && $urandom_range(0, 99) < send_idle_pct) begin
                  send_gap = $urandom_range(1, 13);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor: compare each transfer with the oldest prediction, stall at random
   always @(posedge clock) begin
      branch_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_branches.size() == 0) begin
               $error("unexpected result: size %0d kind %0d target %h ends_block %0b",
                      rsp_insn_size, rsp_branch_kind, rsp_branch_target, rsp_ends_block);
               mismatch_count++;
            end else begin
               want = predicted_branches.pop_front();
               if (rsp_insn_size !== want.size) begin
                  $error("insn_size: expected %0d, actual %0d", want.size, rsp_insn_size);
                  mismatch_count++;
               end
               if (rsp_branch_kind !== want.kind) begin
                  $error("branch_kind: expected %0d, actual %0d", want.kind, rsp_branch_kind);
                  mismatch_count++;
               end
               if (rsp_branch_target !== want.target) begin
                  $error("branch_target: expected %h, actual %h", want.target,
                         rsp_branch_target);
                  mismatch_count++;
               end
               if (rsp_ends_block !== want.ends_block) begin
                  $error("ends_block: expected %0b, actual %0b", want.ends_block,
                         rsp_ends_block);
                  mismatch_count++;
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap = recv_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (fetch_queue.size() > CALM_TAIL && $urandom_range(0, 99) < recv_idle_pct) begin
               recv_gap = $urandom_range(1, 13);
            end
         end
      end
   end

   // stimulus, reset, drain and verdict
   initial begin
      // thumb16 conditional: positive, negative with wrap, condition 111x
      queue_fetch(32'h00001000, 1'b1, 16'hD07F, 16'h0000);
      queue_fetch(32'h00000000, 1'b1, 16'hD180, 16'hFFFF);
      queue_fetch(32'h00002000, 1'b1, 16'hDEFF, 16'h1234);
      queue_fetch(32'h00002002, 1'b1, 16'hDF00, 16'h0000);
      // thumb16 direct: largest forward, backward, wrap past the top
      queue_fetch(32'h00000100, 1'b1, 16'hE3FF, 16'h0000);
      queue_fetch(32'h00000100, 1'b1, 16'hE400, 16'hFFFF);
      queue_fetch(32'hFFFFFFFE, 1'b1, 16'hE000, 16'h0000);
      // last 16-bit top bits, first 32-bit top bits
      queue_fetch(32'h00003000, 1'b1, 16'hE7FF, 16'h0000);
      queue_fetch(32'h00003000, 1'b1, 16'hE800, 16'h8000);
      // thumb16 blx register, blx lr, bx lr (no match), pop pc
      queue_fetch(32'h00004000, 1'b1, 16'h4788, 16'h0000);
      queue_fetch(32'h00004000, 1'b1, 16'h47F0, 16'h0000);
      queue_fetch(32'h00004000, 1'b1, 16'h4770, 16'h0000);
      queue_fetch(32'hFFFFFFFF, 1'b1, 16'hBDFF, 16'hFFFF);
      // thumb32 b.w, bcond.w with both signs, bl, table branch, no match
      queue_fetch(32'h00005000, 1'b1, 16'hF000, 16'h8000);
      queue_fetch(32'h00005000, 1'b1, 16'hF7FF, 16'hBFFF);
      queue_fetch(32'h00005000, 1'b1, 16'hF000, 16'h9000);
      queue_fetch(32'h00000000, 1'b1, 16'hF7FF, 16'hFFFF);
      queue_fetch(32'hFFFFFFFC, 1'b1, 16'hF400, 16'hD000);
      queue_fetch(32'h00006000, 1'b1, 16'hE89F, 16'hD01F);
      queue_fetch(32'h00006000, 1'b1, 16'hFFFF, 16'hFFFF);
      // arm b backward, largest forward, cond 1111, bx lr, bx, blx, ldm pc, no match
      queue_fetch(32'h00008000, 1'b0, 16'hFFFE, 16'hEAFF);
      queue_fetch(32'hFFFFFFF0, 1'b0, 16'hFFFF, 16'h0A7F);
      queue_fetch(32'h00008000, 1'b0, 16'h0000, 16'hFB00);
      queue_fetch(32'h00008000, 1'b0, 16'hFF1E, 16'hE12F);
      queue_fetch(32'h00008000, 1'b0, 16'hFF13, 16'hE12F);
      queue_fetch(32'h00008000, 1'b0, 16'hFF33, 16'hE12F);
      queue_fetch(32'h00008000, 1'b0, 16'h8000, 16'hE8BD);
      queue_fetch(32'h00000000, 1'b0, 16'h0000, 16'hE1A0);
      for (int i = 0; i < RANDOM_FETCHES; i++) begin
         fetch_queue = {fetch_queue, random_fetch()};
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (fetch_queue.size() != 0 || req_valid || predicted_branches.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && predicted_branches.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
